/* design/ulbp_pkg.sv */
package ulbp_pkg;

    // stream and field widths
    localparam int PIXEL_W      = 8;
    localparam int CODE_W       = 6;
    localparam int OUT_TDATA_W  = 8;
    localparam int ROW_W        = 12;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int PATTERN_W    = 8;
    localparam int LUT_DEPTH    = 256;

    // defaults and limits
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int IMAGE_WIDTH_RESET  = 64;
    localparam int IMAGE_HEIGHT_RESET = 64;
    localparam int MIN_DIM            = 3;
    localparam int BORDER             = 2;
    localparam int MAX_TRANSITIONS    = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // one column of the 3x3 window
    typedef struct packed {
        logic [PIXEL_W-1:0] top;
        logic [PIXEL_W-1:0] mid;
        logic [PIXEL_W-1:0] bot;
    } column_t;

    typedef logic [CODE_W-1:0] code_lut_t [LUT_DEPTH];

    // rank of each uniform pattern, zero for the rest
    function automatic code_lut_t build_code_lut();
        code_lut_t          lut;
        logic [PATTERN_W-1:0] p;
        logic [PATTERN_W-1:0] x;
        int                 rank;
        rank = 0;
        for (int q = 0; q < LUT_DEPTH; q++)
        begin
            p = PATTERN_W'(q);
            x = p ^ {p[PATTERN_W-2:0], p[PATTERN_W-1]};
            if ($countones(x) <= MAX_TRANSITIONS)
            begin
                rank   = rank + 1;
                lut[q] = CODE_W'(rank);
            end
            else
            begin
                lut[q] = '0;
            end
        end
        return lut;
    endfunction

    localparam code_lut_t CODE_LUT = build_code_lut();

endpackage

/* design/ulbp_line_store.sv */
module ulbp_line_store #(
    parameter int MAX_WIDTH = ulbp_pkg::DEFAULT_MAX_WIDTH,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [ulbp_pkg::PIXEL_W-1:0] wr_pixel,
    output logic [ulbp_pkg::PIXEL_W-1:0] up_pixel,
    output logic [ulbp_pkg::PIXEL_W-1:0] mid_pixel
);

    logic [ulbp_pkg::PIXEL_W-1:0] upper_mem [MAX_WIDTH];
    logic [ulbp_pkg::PIXEL_W-1:0] middle_mem [MAX_WIDTH];
    logic [ulbp_pkg::PIXEL_W-1:0] up_rd_reg;
    logic [ulbp_pkg::PIXEL_W-1:0] mid_rd_reg;

    // registered reads, held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            up_rd_reg  <= upper_mem[rd_addr];
            mid_rd_reg <= middle_mem[rd_addr];
        end
    end

    // write back: middle row moves up, new pixel takes its place
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= mid_rd_reg;
            middle_mem[wr_addr] <= wr_pixel;
        end
    end

    assign up_pixel  = up_rd_reg;
    assign mid_pixel = mid_rd_reg;

endmodule

/* design/uniform_lbp59_pixel_coder.sv */
// pipeline: a pixel accepted on the slave side reaches the master side through the
//   registered line store read, window compare and code lookup stages
// throughput: one pixel per cycle unless the master side stalls; each line store does one
//   read and one write-back per cycle on separate ports
// reset: position counters, window and stage valids clear, sizes return to 64x64 (width at most MAX_WIDTH);
//   line store contents are not cleared
module uniform_lbp59_pixel_coder #(
    parameter int MAX_WIDTH = ulbp_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ulbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ulbp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ulbp_pkg::PIXEL_W-1:0]     s_axis_tdata,  // [7:0] pixel
    // code output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ulbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [5:0] lbp_code, [7:6] zero
    output logic                             m_axis_tuser,  // [0] code_valid
    output logic                             m_axis_tlast   // frame_last
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW0  = $clog2(MAX_WIDTH + 1);
    localparam int EW   = (EW0 > ulbp_pkg::CFG_WIDTH_W) ? EW0 : ulbp_pkg::CFG_WIDTH_W;
    localparam int WIDTH_RESET = (ulbp_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                                 MAX_WIDTH : ulbp_pkg::IMAGE_WIDTH_RESET;
    localparam int RW   = ulbp_pkg::ROW_W;
    localparam int PW   = ulbp_pkg::PIXEL_W;

    // configuration, stored already clamped
    logic [EW-1:0] width_reg;
    logic [RW-1:0] height_reg;
    logic [ulbp_pkg::CFG_WIDTH_W-1:0] cfg_width;
    logic [RW-1:0] cfg_height;
    logic [EW-1:0] width_next;
    logic [RW-1:0] height_next;

    // position
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic [EW-1:0] col_plus;
    logic [RW:0]   row_plus;
    logic          row_end;
    logic          frame_end;
    logic          inner;

    // stage handshake
    logic out_en;
    logic s2_en;
    logic s1_en;
    logic in_accept;
    logic s1_move;

    // stage 1: line store read in flight
    logic          s1_valid_reg;
    logic [PW-1:0] s1_pixel_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_inner_reg;
    logic          s1_last_reg;

    // stage 2: pattern
    logic                            s2_valid_reg;
    logic [ulbp_pkg::PATTERN_W-1:0]  s2_pattern_reg;
    logic                            s2_inner_reg;
    logic                            s2_last_reg;

    // output register
    logic                            out_valid_reg;
    logic [ulbp_pkg::CODE_W-1:0]     out_code_reg;
    logic                            out_inner_reg;
    logic                            out_last_reg;

    // window: left and centre columns after the last shift
    ulbp_pkg::column_t ctr_col_reg;
    ulbp_pkg::column_t rgt_col_reg;
    ulbp_pkg::column_t new_col;
    logic [PW-1:0]     up_pixel;
    logic [PW-1:0]     mid_pixel;
    logic [ulbp_pkg::PATTERN_W-1:0] pattern;

    // configuration clamp
    assign cfg_ready  = 1'b1;
    assign cfg_width  = cfg_data[ulbp_pkg::CFG_WIDTH_W-1:0];
    assign cfg_height = cfg_data[RW-1:0];

    always_comb
    begin
        if (EW'(cfg_width) < EW'(ulbp_pkg::MIN_DIM))
            width_next = EW'(ulbp_pkg::MIN_DIM);
        else if (EW'(cfg_width) > EW'(MAX_WIDTH))
            width_next = EW'(MAX_WIDTH);
        else
            width_next = EW'(cfg_width);

        if (cfg_height < RW'(ulbp_pkg::MIN_DIM))
            height_next = RW'(ulbp_pkg::MIN_DIM);
        else
            height_next = cfg_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= EW'(WIDTH_RESET);
            height_reg <= RW'(ulbp_pkg::IMAGE_HEIGHT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ulbp_pkg::REG_IMAGE_WIDTH:  width_reg  <= width_next;
                ulbp_pkg::REG_IMAGE_HEIGHT: height_reg <= height_next;
                default: ;
            endcase
        end
    end

    // stage enables, each stage moves when the one after it has room
    assign out_en        = !out_valid_reg || m_axis_tready;
    assign s2_en         = !s2_valid_reg || out_en;
    assign s1_en         = !s1_valid_reg || s2_en;
    assign s_axis_tready = s1_en;
    assign in_accept     = s_axis_tvalid && s1_en;
    assign s1_move       = s1_valid_reg && s2_en;

    // position of the incoming pixel and where the next one lands
    assign col_plus  = EW'(col_reg) + EW'(1);
    assign row_plus  = (RW+1)'(row_reg) + (RW+1)'(1);
    assign row_end   = col_plus >= width_reg;
    assign frame_end = row_end && (row_plus >= (RW+1)'(height_reg));
    assign inner     = (row_reg >= RW'(ulbp_pkg::BORDER)) && (col_reg >= CW'(ulbp_pkg::BORDER));

    always_comb
    begin
        col_next = row_end ? '0 : col_plus[CW-1:0];
        if (!row_end)
            row_next = row_reg;
        else if (frame_end)
            row_next = '0;
        else
            row_next = row_plus[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores: read on request, write back when stage 1 moves on;
    // consecutive pixels never share a column, so no forwarding is needed
    ulbp_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (CW)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (in_accept),
        .rd_addr   (col_reg),
        .wr_en     (s1_move),
        .wr_addr   (s1_col_reg),
        .wr_pixel  (s1_pixel_reg),
        .up_pixel  (up_pixel),
        .mid_pixel (mid_pixel)
    );

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= s_axis_tdata;
            s1_col_reg   <= col_reg;
            s1_inner_reg <= inner;
            s1_last_reg  <= frame_end;
        end
    end

    // new right column and neighbor compares against the centre
    assign new_col = '{top: up_pixel, mid: mid_pixel, bot: s1_pixel_reg};

    always_comb
    begin
        pattern[0] = ctr_col_reg.mid >= rgt_col_reg.mid;  // left
        pattern[1] = ctr_col_reg.bot >= rgt_col_reg.mid;  // lower-left
        pattern[2] = rgt_col_reg.bot >= rgt_col_reg.mid;  // below
        pattern[3] = new_col.bot     >= rgt_col_reg.mid;  // lower-right
        pattern[4] = new_col.mid     >= rgt_col_reg.mid;  // right
        pattern[5] = new_col.top     >= rgt_col_reg.mid;  // upper-right
        pattern[6] = rgt_col_reg.top >= rgt_col_reg.mid;  // above
        pattern[7] = ctr_col_reg.top >= rgt_col_reg.mid;  // upper-left
    end

    // window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_col_reg <= '0;
            rgt_col_reg <= '0;
        end
        else if (s1_move)
        begin
            ctr_col_reg <= rgt_col_reg;
            rgt_col_reg <= new_col;
        end
    end

    // stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_pattern_reg <= pattern;
            s2_inner_reg   <= s1_inner_reg;
            s2_last_reg    <= s1_last_reg;
        end
    end

    // code lookup into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_en)
        begin
            out_code_reg  <= s2_inner_reg ? ulbp_pkg::CODE_LUT[s2_pattern_reg] : '0;
            out_inner_reg <= s2_inner_reg;
            out_last_reg  <= s2_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(ulbp_pkg::OUT_TDATA_W - ulbp_pkg::CODE_W){1'b0}}, out_code_reg};
    assign m_axis_tuser  = out_inner_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* design/ulbp_checker.sv */
module ulbp_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [ulbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             m_axis_tuser,
    input  logic                             m_axis_tlast
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // border centres carry code zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("border result with nonzero code");

    // codes stay within the 59 levels
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= ulbp_pkg::OUT_TDATA_W'(58))
        else $error("code out of range");

    // the last pixel of a frame always centres an inner window
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("frame end on a border centre");

endmodule

bind uniform_lbp59_pixel_coder ulbp_checker u_ulbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
